// ===== hw/rtl/bayer_bilinear_demosaic_assert.svh =====
// ----------------------------------------------------------------------------
// bayer demosaic assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH
`define BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH

// condition that holds at every edge
`define BDM_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define BDM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BDM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bdm_pkg.sv =====
// ----------------------------------------------------------------------------
// bdm_pkg
// types and constants shared by the bayer demosaic modules
// ----------------------------------------------------------------------------
package bdm_pkg;

   localparam int PIX_W      = 8;
   localparam int IMG_W_W    = 12;
   localparam int IMG_H_W    = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [0:0] {
      FUNC_PUSH  = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   // one item as it leaves the sequencer for the window stage
   typedef struct packed {
      logic             valid;
      logic             push;
      logic [PIX_W-1:0] pixel;
      logic             emit;
      logic             row_odd;
      logic             col_odd;
      logic             up;
      logic             down;
      logic             left;
      logic             right;
      logic             frame_end;
   } item_type;

endpackage

// ===== hw/rtl/bdm_seq.sv =====
// ----------------------------------------------------------------------------
// bdm_seq
// input and output position counters, pending count and line ram address
// ----------------------------------------------------------------------------
`include "bayer_bilinear_demosaic_assert.svh"

module bdm_seq #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            func,
   input  logic [bdm_pkg::PIX_W-1:0]       pixel,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]  w_eff,
   input  logic [bdm_pkg::IMG_H_W-1:0]     h_eff,
   output bdm_pkg::item_type               item,
   output logic [$clog2(MAX_WIDTH)-1:0]    addr
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int PW = $clog2(MAX_WIDTH + 2);
   localparam int HW = bdm_pkg::IMG_H_W;

   logic [AW-1:0] in_col_ff,  in_col_in;
   logic [HW-1:0] in_line_ff, in_line_in;
   logic [AW-1:0] out_col_ff, out_col_in;
   logic [HW-1:0] out_line_ff, out_line_in;
   logic [PW-1:0] pending_ff, pending_in;

   logic          at_start;
   logic          is_drain;
   logic          abandon;
   logic [PW-1:0] pend_base;
   logic [PW:0]   pend_inc;
   logic [AW-1:0] oc;
   logic [HW-1:0] ol;
   logic          oc_last;
   logic          in_col_last;
   logic          emit;

   always_comb begin
      at_start    = (in_line_ff == '0) && (in_col_ff == '0);
      is_drain    = (func == bdm_pkg::FUNC_DRAIN);
      // a push at frame start after a partial drain drops the old frame
      abandon     = !is_drain && at_start && (pending_ff != '0) &&
                    (32'(pending_ff) <= 32'(w_eff));
      pend_base   = abandon ? '0 : pending_ff;
      pend_inc    = {1'b0, pend_base} + 1'b1;
      oc          = abandon ? '0 : out_col_ff;
      ol          = abandon ? '0 : out_line_ff;
      oc_last     = (32'(oc) + 1) >= 32'(w_eff);
      in_col_last = (32'(in_col_ff) + 1) >= 32'(w_eff);

      if (is_drain) begin
         emit = at_start && (pending_ff != '0);
      end else begin
         emit = 32'(pend_inc) > (32'(w_eff) + 1);
      end

      in_col_in   = in_col_ff;
      in_line_in  = in_line_ff;
      out_col_in  = oc;
      out_line_in = ol;
      pending_in  = pend_base;

      if (!is_drain) begin
         if (in_col_last) begin
            in_col_in  = '0;
            in_line_in = ((32'(in_line_ff) + 1) >= 32'(h_eff)) ? '0 : in_line_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         // an emitting push leaves the count where it was
         pending_in = emit ? pend_base : PW'(pend_inc);
      end else if (emit) begin
         pending_in = pending_ff - 1'b1;
      end

      if (emit) begin
         if (oc_last) begin
            out_col_in  = '0;
            out_line_in = ((32'(ol) + 1) >= 32'(h_eff)) ? '0 : ol + 1'b1;
         end else begin
            out_col_in = oc + 1'b1;
         end
      end

      // drains fetch the column after the one being output
      if (is_drain) begin
         addr = oc_last ? '0 : oc + 1'b1;
      end else begin
         addr = in_col_ff;
      end

      item.valid     = !is_drain || emit;
      item.push      = !is_drain;
      item.pixel     = pixel;
      item.emit      = emit;
      item.row_odd   = ol[0];
      item.col_odd   = oc[0];
      item.up        = (ol != '0);
      item.down      = (32'(ol) + 1) < 32'(h_eff);
      item.left      = (oc != '0);
      item.right     = !oc_last;
      item.frame_end = ((32'(ol) + 1) == 32'(h_eff)) && ((32'(oc) + 1) == 32'(w_eff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_line_ff  <= '0;
         out_col_ff  <= '0;
         out_line_ff <= '0;
         pending_ff  <= '0;
      end else if (accept) begin
         in_col_ff   <= in_col_in;
         in_line_ff  <= in_line_in;
         out_col_ff  <= out_col_in;
         out_line_ff <= out_line_in;
         pending_ff  <= pending_in;
      end
   end

   `BDM_ASSERT_ALWAYS(a_pending_bound, 32'(pending_ff) <= (MAX_WIDTH + 1), "pending count overflow")
   `BDM_ASSERT_ALWAYS(a_in_col_bound, 32'(in_col_ff) < MAX_WIDTH, "input column beyond line ram")
   `BDM_ASSERT_IMPL(a_drain_emit, accept && item.emit && !item.push, pending_ff != '0,
                    "drain emitted with nothing pending")

endmodule

// ===== hw/rtl/bdm_line_ram.sv =====
// ----------------------------------------------------------------------------
// bdm_line_ram
// two-line buffer, one entry per column holding older and newer sample
// ----------------------------------------------------------------------------
module bdm_line_ram #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
   output logic [2*bdm_pkg::PIX_W-1:0]     rd_data,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
   input  logic [2*bdm_pkg::PIX_W-1:0]     wr_data
);

   localparam int DW = 2 * bdm_pkg::PIX_W;

   logic [DW-1:0] mem [MAX_WIDTH];
   logic [DW-1:0] rdata_ff;
   logic [DW-1:0] fwd_data_ff;
   logic          fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read and a same-address write in one cycle: hand over the new entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff    <= mem[rd_addr];
         fwd_data_ff <= wr_data;
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rdata_ff;

endmodule

// ===== hw/rtl/bdm_interp.sv =====
// ----------------------------------------------------------------------------
// bdm_interp
// 3x3 window update, bilinear averages, line ram write-back and output item
// ----------------------------------------------------------------------------
`include "bayer_bilinear_demosaic_assert.svh"

module bdm_interp #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  bdm_pkg::item_type               item_in,
   input  logic [$clog2(MAX_WIDTH)-1:0]    addr_in,
   input  logic [2*bdm_pkg::PIX_W-1:0]     rd_data,
   output logic                            wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
   output logic [2*bdm_pkg::PIX_W-1:0]     wr_data,
   output logic                            busy,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [bdm_pkg::PIX_W-1:0]       rsp_red,
   output logic [bdm_pkg::PIX_W-1:0]       rsp_green,
   output logic [bdm_pkg::PIX_W-1:0]       rsp_blue,
   output logic                            rsp_frame_end
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int PX = bdm_pkg::PIX_W;

   bdm_pkg::item_type s1_ff;
   logic [AW-1:0]     s1_addr_ff;

   logic [PX-1:0] win_ff [3][3];
   logic [PX-1:0] k      [3][3];
   logic [PX-1:0] col    [3];

   logic          rsp_valid_ff;
   logic [PX-1:0] red_ff, green_ff, blue_ff;
   logic          frame_end_ff;

   logic          move;
   logic [PX:0]   horiz_sum, vert_sum;
   logic [PX+1:0] diag_sum;
   logic [PX-1:0] horiz, vert, diag, centre;
   logic [PX-1:0] red_in, green_in, blue_in;
   logic          both_ud, both_lr;

   assign move = s1_ff.valid && (!s1_ff.emit || !rsp_valid_ff || !rsp_stall);
   assign busy = s1_ff.valid && !move;

   assign wr_en   = move && s1_ff.push;
   assign wr_addr = s1_addr_ff;
   assign wr_data = {rd_data[PX-1:0], s1_ff.pixel};

   always_comb begin
      col[0] = rd_data[2*PX-1:PX];
      col[1] = rd_data[PX-1:0];
      // drains shift in a bottom sample outside the image
      col[2] = s1_ff.push ? s1_ff.pixel : '0;
      for (int r = 0; r < 3; r++) begin
         k[r][0] = win_ff[r][1];
         k[r][1] = win_ff[r][2];
         k[r][2] = col[r];
      end

      both_ud = s1_ff.up && s1_ff.down;
      both_lr = s1_ff.left && s1_ff.right;

      horiz_sum = {1'b0, s1_ff.left  ? k[1][0] : '0} + {1'b0, s1_ff.right ? k[1][2] : '0};
      vert_sum  = {1'b0, s1_ff.up    ? k[0][1] : '0} + {1'b0, s1_ff.down  ? k[2][1] : '0};
      diag_sum  = {2'b00, (s1_ff.up   && s1_ff.left)  ? k[0][0] : '0}
                + {2'b00, (s1_ff.up   && s1_ff.right) ? k[0][2] : '0}
                + {2'b00, (s1_ff.down && s1_ff.left)  ? k[2][0] : '0}
                + {2'b00, (s1_ff.down && s1_ff.right) ? k[2][2] : '0};

      horiz = both_lr ? horiz_sum[PX:1] : horiz_sum[PX-1:0];
      vert  = both_ud ? vert_sum[PX:1]  : vert_sum[PX-1:0];
      if (both_ud && both_lr) begin
         diag = diag_sum[PX+1:2];
      end else if (both_ud || both_lr) begin
         diag = diag_sum[PX:1];
      end else begin
         diag = diag_sum[PX-1:0];
      end
      centre = k[1][1];

      case ({s1_ff.row_odd, s1_ff.col_odd})
         2'b00: begin
            red_in = centre; green_in = horiz; blue_in = diag;
         end
         2'b11: begin
            red_in = diag; green_in = horiz; blue_in = centre;
         end
         2'b01: begin
            red_in = horiz; green_in = centre; blue_in = vert;
         end
         default: begin
            red_in = vert; green_in = centre; blue_in = horiz;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (accept) begin
         s1_ff <= item_in;
      end else if (move) begin
         s1_ff.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (move) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= k[r][c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move && s1_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move && s1_ff.emit) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         frame_end_ff <= s1_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_frame_end = frame_end_ff;

   `BDM_ASSERT_NEXT(a_s1_hold, s1_ff.valid && !move, $stable(s1_ff) && $stable(s1_addr_ff),
                    "held window-stage item changed")
   `BDM_ASSERT_NEXT(a_emit_loads, move && s1_ff.emit, rsp_valid_ff,
                    "emitting item did not reach the output register")
   `BDM_ASSERT_IMPL(a_no_accept_busy, busy, !accept, "item accepted while window stage blocked")

endmodule

// ===== hw/rtl/bayer_bilinear_demosaic.sv =====
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// bilinear rggb demosaic, raw samples in raster order to one rgb pixel each
// ----------------------------------------------------------------------------
// Takes one item per clock, push or drain, and gives at most one rgb item per
// item, so the sustained rate is one item per cycle while the output is not
// stalled. An item goes through two stages: the first updates the position
// counters and reads the two-line ram at the column in use, the second shifts
// the 3x3 window, writes the column back and loads the output register. Output
// for a position lags its sample by width+1 samples; at frame end, drain items
// issued at the start of the next frame flush the last width+1 pixels. The line
// ram needs no clearing after reset: entries never written only feed neighbours
// outside the image. The user must write width and height over the csr port
// (offset 0 and 4) only while the block is idle; the block does not enforce it.

module bayer_bilinear_demosaic #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [bdm_pkg::PIX_W-1:0]          req_raw_pixel,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bdm_pkg::PIX_W-1:0]          rsp_red,
   output logic [bdm_pkg::PIX_W-1:0]          rsp_green,
   output logic [bdm_pkg::PIX_W-1:0]          rsp_blue,
   output logic                               rsp_frame_end,

   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bdm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bdm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bdm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int DW = 2 * bdm_pkg::PIX_W;

   logic [bdm_pkg::IMG_W_W-1:0] width_ff;
   logic [bdm_pkg::IMG_H_W-1:0] height_ff;
   logic [WW-1:0]               w_eff;
   logic [bdm_pkg::IMG_H_W-1:0] h_eff;
   bdm_pkg::reg_index_type      csr_index;
   logic                        csr_write;

   logic                        accept;
   logic                        busy;
   bdm_pkg::item_type           item;
   logic [AW-1:0]               rd_addr;
   logic [DW-1:0]               rd_data;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [DW-1:0]               wr_data;

   assign csr_pready = 1'b1;
   assign csr_index  = bdm_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bdm_pkg::IMAGE_WIDTH_RESET;
         height_ff <= bdm_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            bdm_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[bdm_pkg::IMG_W_W-1:0];
            bdm_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[bdm_pkg::IMG_H_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bdm_pkg::REG_IMAGE_WIDTH:  csr_prdata = bdm_pkg::CSR_DATA_W'(width_ff);
         bdm_pkg::REG_IMAGE_HEIGHT: csr_prdata = bdm_pkg::CSR_DATA_W'(height_ff);
      endcase
   end

   // effective sizes: width clamped to the line ram, both at least two
   always_comb begin
      if (32'(width_ff) < 2) begin
         w_eff = WW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      h_eff = (height_ff < bdm_pkg::IMG_H_W'(2)) ? bdm_pkg::IMG_H_W'(2) : height_ff;
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   bdm_seq #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .func   (req_func),
      .pixel  (req_raw_pixel),
      .w_eff  (w_eff),
      .h_eff  (h_eff),
      .item   (item),
      .addr   (rd_addr)
   );

   bdm_line_ram #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bdm_interp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_interp (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .item_in       (item),
      .addr_in       (rd_addr),
      .rd_data       (rd_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .busy          (busy),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
